### rtl/tdfe_pkg.sv
// Package for the table-driven state machine engine.
// Holds widths, command and result codes, and the structs shared by the cells, ring and top.
// Has no dependencies and is compiled first.
package tdfe_pkg;

   localparam int STATES          = 32;
   localparam int STATE_W         = $clog2(STATES);
   localparam int EVENT_W         = 8;
   localparam int CMD_W           = 2;
   localparam int DEF_TRANSITIONS = 16;
   localparam int DEF_EVENT_SLOTS = 2;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int REG_START_STATE = 0;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_TICK = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_STEP   = 2'd1,
      KIND_UPDATE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_TABLE_FULL = 2'd1,
      STAT_QUEUE_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [STATE_W-1:0] origin;
      logic [EVENT_W-1:0] event_code;
   } probe_type;

   typedef struct packed {
      logic [STATE_W-1:0] from_state;
      logic [EVENT_W-1:0] event_code;
      logic [STATE_W-1:0] to_state;
   } row_type;

   typedef struct packed {
      logic               hit;
      logic               done;
      logic [STATE_W-1:0] to_state;
   } cell_status_type;

   typedef struct packed {
      logic               push;
      logic               pop;
      logic [EVENT_W-1:0] push_event;
   } ring_ctrl_type;

   typedef struct packed {
      logic               full;
      logic               empty;
      logic [EVENT_W-1:0] head_event;
   } ring_stat_type;

endpackage

### rtl/tdfe_req_if.sv
// Request channel of the state machine engine: valid, ready and one command transaction.
// Depends on tdfe_pkg for field widths.
interface tdfe_req_if import tdfe_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [EVENT_W-1:0] event_code;
   logic [STATE_W-1:0] from_state;
   logic [STATE_W-1:0] to_state;

   modport source (output valid, command, event_code, from_state, to_state, input ready);
   modport sink (input valid, command, event_code, from_state, to_state, output ready);

endinterface

### rtl/tdfe_rsp_if.sv
// Response channel of the state machine engine: valid, ready and one result transaction.
// Depends on tdfe_pkg for field widths and codes.
interface tdfe_rsp_if import tdfe_pkg::*; ();

   logic               valid;
   logic               ready;
   kind_type           kind;
   status_type         status;
   logic [STATE_W-1:0] exited_state;
   logic [STATE_W-1:0] entered_state;
   logic [STATE_W-1:0] current_state;
   logic               last;

   modport source (output valid, kind, status, exited_state, entered_state, current_state,
                   last, input ready);
   modport sink (input valid, kind, status, exited_state, entered_state, current_state,
                 last, output ready);

endinterface

### rtl/table_driven_fsm_engine_unit.sv
// Top level of the table-driven state machine engine.
// Depends on tdfe_pkg, tdfe_req_if, tdfe_rsp_if, tdfe_cell and tdfe_ring.
//
// Usage: each request transaction carries a command. A load appends a transition row
// (from, event, to) and a push queues an event; each answers with one status transaction
// in the cycle after acceptance. A tick pops the oldest queued event and sends a probe
// down a chain of TRANSITIONS cells, one cell per cycle unless held at a matching cell.
// Each matching row yields an exit/entry transaction, and the tick closes with an update
// transaction marked last. A new request is taken only once the previous tick has
// finished its scan. The result sits in an output register, and a request is accepted
// only when that register is empty or is being read in the same cycle. When the receiver
// stalls, the probe holds at a matching cell until the pending result is taken. Reset
// empties the table and the event queue and sets the state to zero. Writing start_state
// at byte address 0 through the APB port also loads the current state; pready is always
// high.
module table_driven_fsm_engine_unit import tdfe_pkg::*; #(
   parameter int TRANSITIONS = DEF_TRANSITIONS,
   parameter int EVENT_SLOTS = DEF_EVENT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   tdfe_req_if.sink              req_chan,
   tdfe_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W = $clog2(TRANSITIONS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } fsm_type;

   fsm_type            state_ff;
   fsm_type            state_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [STATE_W-1:0] start_ff;
   logic [STATE_W-1:0] start_in;
   logic [STATE_W-1:0] machine_ff;
   logic [STATE_W-1:0] machine_in;
   logic [STATE_W-1:0] scan_from_ff;
   logic [STATE_W-1:0] scan_from_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   kind_type           rsp_kind_ff;
   kind_type           rsp_kind_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic [STATE_W-1:0] rsp_exited_ff;
   logic [STATE_W-1:0] rsp_exited_in;
   logic [STATE_W-1:0] rsp_entered_ff;
   logic [STATE_W-1:0] rsp_entered_in;
   logic [STATE_W-1:0] rsp_current_ff;
   logic [STATE_W-1:0] rsp_current_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;

   logic               out_free;
   logic               req_ready;
   logic               req_fire;
   logic               cfg_write;
   logic               table_full;
   logic               load_ok;
   logic               inject;
   logic               advance;
   logic               flush;
   logic               any_hit;
   logic               any_done;
   logic               any_probe;
   logic [STATE_W-1:0] hit_to;

   ring_ctrl_type      ring_ctrl;
   ring_stat_type      ring_stat;
   row_type            write_row;
   probe_type          probe_head;
   probe_type          probe_chain [TRANSITIONS];
   cell_status_type    cell_stat [TRANSITIONS];
   logic [TRANSITIONS-1:0] probe_valid_vec;
   logic [TRANSITIONS-1:0] write_en;
   logic [TRANSITIONS-1:0] row_valid;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_chan.valid && req_ready;
   assign cfg_write  = psel && penable && pwrite && (paddr[2] == 1'(REG_START_STATE));
   assign table_full = (count_ff == CNT_W'(TRANSITIONS));
   assign load_ok    = req_fire && (req_chan.command == CMD_LOAD) && !table_full;
   assign inject     = req_fire && (req_chan.command == CMD_TICK) && !ring_stat.empty;
   assign advance    = !((state_ff == ST_SCAN) && any_hit && !out_free);

   always_comb begin
      write_row.from_state = req_chan.from_state;
      write_row.event_code = req_chan.event_code;
      write_row.to_state   = req_chan.to_state;
      probe_head.valid      = inject;
      probe_head.origin     = machine_ff;
      probe_head.event_code = ring_stat.head_event;
      ring_ctrl.push       = req_fire && (req_chan.command == CMD_PUSH);
      ring_ctrl.pop        = inject;
      ring_ctrl.push_event = req_chan.event_code;
   end

   tdfe_ring #(
      .SLOTS (EVENT_SLOTS)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctrl_i (ring_ctrl),
      .stat_o (ring_stat)
   );

   for (genvar i = 0; i < TRANSITIONS; i++) begin : g_cell
      assign write_en[i]        = load_ok && (count_ff == CNT_W'(i));
      assign row_valid[i]       = CNT_W'(i) < count_ff;
      assign probe_valid_vec[i] = probe_chain[i].valid;

      tdfe_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .flush     (flush),
         .row_valid (row_valid[i]),
         .write_en  (write_en[i]),
         .write_row (write_row),
         .probe_i   ((i == 0) ? probe_head : probe_chain[(i == 0) ? 0 : i - 1]),
         .probe_o   (probe_chain[i]),
         .status_o  (cell_stat[i])
      );
   end

   always_comb begin
      any_hit  = 1'b0;
      any_done = 1'b0;
      hit_to   = '0;
      for (int i = 0; i < TRANSITIONS; i++) begin
         any_hit  = any_hit || cell_stat[i].hit;
         any_done = any_done || cell_stat[i].done;
         hit_to   = hit_to | cell_stat[i].to_state;
      end
      any_probe = |probe_valid_vec;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      start_in       = start_ff;
      machine_in     = machine_ff;
      scan_from_in   = scan_from_ff;
      flush          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_exited_in  = rsp_exited_ff;
      rsp_entered_in = rsp_entered_ff;
      rsp_current_in = rsp_current_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rsp_status_in  = STAT_OK;
               rsp_exited_in  = '0;
               rsp_entered_in = '0;
               rsp_current_in = machine_ff;
               rsp_last_in    = 1'b1;
               case (req_chan.command)
                  CMD_LOAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_STATUS;
                     if (table_full) begin
                        rsp_status_in = STAT_TABLE_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_STATUS;
                     if (ring_stat.full) begin
                        rsp_status_in = STAT_QUEUE_FULL;
                     end
                  end
                  CMD_TICK: begin
                     if (ring_stat.empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_UPDATE;
                     end else begin
                        scan_from_in = machine_ff;
                        state_in     = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (any_hit) begin
               if (out_free) begin
                  machine_in     = hit_to;
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_STEP;
                  rsp_status_in  = STAT_OK;
                  rsp_exited_in  = scan_from_ff;
                  rsp_entered_in = hit_to;
                  rsp_current_in = hit_to;
                  rsp_last_in    = 1'b0;
               end
            end else if (!any_probe || any_done) begin
               if (out_free) begin
                  flush          = 1'b1;
                  state_in       = ST_IDLE;
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_UPDATE;
                  rsp_status_in  = STAT_OK;
                  rsp_exited_in  = '0;
                  rsp_entered_in = '0;
                  rsp_current_in = machine_ff;
                  rsp_last_in    = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_write) begin
         start_in   = pwdata[STATE_W-1:0];
         machine_in = pwdata[STATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         start_ff     <= '0;
         machine_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         machine_ff   <= machine_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_from_ff   <= scan_from_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_exited_ff  <= rsp_exited_in;
      rsp_entered_ff <= rsp_entered_in;
      rsp_current_ff <= rsp_current_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.exited_state  = rsp_exited_ff;
   assign rsp_chan.entered_state = rsp_entered_ff;
   assign rsp_chan.current_state = rsp_current_ff;
   assign rsp_chan.last          = rsp_last_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'(REG_START_STATE)) ?
                   CSR_DATA_W'(start_ff) : '0;

   a_single_probe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(probe_valid_vec))
      else $error("More than one probe is travelling through the cell chain.");

   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_chan.ready)
      else $error("A request was offered ready while a scan is running.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TRANSITIONS))
      else $error("The transition count exceeds the table size.");

   a_result_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_current_ff == machine_ff))
      else $error("A pending result disagrees with the held machine state.");

   a_step_entered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_STEP)) |->
         ((rsp_current_ff == rsp_entered_ff) && !rsp_last_ff))
      else $error("An exit/entry transaction is malformed.");

endmodule

### rtl/tdfe_cell.sv
// One cell of the transition chain: holds one table row and the scan probe passing through.
// Depends on tdfe_pkg for the row, probe and status structs.
module tdfe_cell import tdfe_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            flush,
   input  logic            row_valid,
   input  logic            write_en,
   input  row_type         write_row,
   input  probe_type       probe_i,
   output probe_type       probe_o,
   output cell_status_type status_o
);

   row_type   row_ff;
   row_type   row_in;
   probe_type probe_ff;
   probe_type probe_in;
   logic      match;

   always_comb begin
      row_in = write_en ? write_row : row_ff;
      probe_in = probe_ff;
      if (flush) begin
         probe_in.valid = 1'b0;
      end else if (advance) begin
         probe_in = probe_i;
      end
   end

   assign match = (row_ff.from_state == probe_ff.origin) &&
                  (row_ff.event_code == probe_ff.event_code);

   always_comb begin
      status_o.hit      = probe_ff.valid && row_valid && match;
      status_o.done     = probe_ff.valid && !row_valid;
      status_o.to_state = status_o.hit ? row_ff.to_state : '0;
   end

   assign probe_o = probe_ff;

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

endmodule

### rtl/tdfe_ring.sv
// Event ring of the state machine engine, one slot always kept empty.
// Depends on tdfe_pkg for the ring control and status structs.
module tdfe_ring import tdfe_pkg::*; #(
   parameter int SLOTS = DEF_EVENT_SLOTS
) (
   input  logic          clock,
   input  logic          reset,
   input  ring_ctrl_type ctrl_i,
   output ring_stat_type stat_o
);

   localparam int PTR_W = $clog2(SLOTS);

   logic [EVENT_W-1:0] slots_ff [SLOTS];
   logic [EVENT_W-1:0] slots_in [SLOTS];
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   head_in;
   logic [PTR_W-1:0]   tail_ff;
   logic [PTR_W-1:0]   tail_in;
   logic [PTR_W-1:0]   next_head;
   logic [PTR_W-1:0]   next_tail;

   assign next_head = (head_ff == PTR_W'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
   assign next_tail = (tail_ff == PTR_W'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;

   always_comb begin
      stat_o.full       = (next_head == tail_ff);
      stat_o.empty      = (head_ff == tail_ff);
      stat_o.head_event = slots_ff[next_tail];
   end

   always_comb begin
      slots_in = slots_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (ctrl_i.push && !stat_o.full) begin
         slots_in[next_head] = ctrl_i.push_event;
         head_in = next_head;
      end
      if (ctrl_i.pop && !stat_o.empty) begin
         tail_in = next_tail;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

endmodule
